/* rtl/core/graph_local_complement_recolor_macros.svh */
// assertion helpers used by the datapath rtl of the recolor block
`ifndef GRAPH_LOCAL_COMPLEMENT_RECOLOR_MACROS_SVH
`define GRAPH_LOCAL_COMPLEMENT_RECOLOR_MACROS_SVH

// same-cycle implication under synchronous reset
`define GLCR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication under synchronous reset
`define GLCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/glcr_pkg.sv */
`default_nettype none

package glcr_pkg;

   // field widths
   localparam int MODE_W   = 2;
   localparam int VERTEX_W = 5;
   localparam int BITS_W   = 32;
   localparam int VC_W     = 6;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   // register map
   localparam logic REG_VERTEX_COUNT = 1'b0;
   localparam logic [VC_W-1:0] VC_RESET = 6'd32;

   // command codes
   typedef enum logic [MODE_W-1:0] {
      MODE_WR_ROW     = 2'd0,
      MODE_WR_COLOR   = 2'd1,
      MODE_COMPLEMENT = 2'd2,
      MODE_RD_ROW     = 2'd3
   } mode_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic a_rd_pivot;
      logic a_wr_row;
      logic color_wr;
      logic color_flip;
      logic nb_load;
      logic cpl_rd;
      logic sweep_rd;
      logic cnt_inc;
      logic out_load;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      mode_type mode;
      logic     ok;
      logic     cnt_last_all;
      logic     cnt_last_act;
      logic     out_free;
   } dp_sts_type;

endpackage

`default_nettype wire

/* rtl/core/glcr_csr.sv */
`default_nettype none

module glcr_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [glcr_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [glcr_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [glcr_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready,
   output logic [glcr_pkg::VC_W-1:0]   vertex_count
);
   import glcr_pkg::*;

   logic [VC_W-1:0] vc_ff;
   logic            hit;

   // register 0 sits at byte address 0, word index is paddr[2]
   assign hit = (csr_paddr[2] == REG_VERTEX_COUNT);

   // write on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= VC_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && hit) begin
         vc_ff <= csr_pwdata[VC_W-1:0];
      end
   end

   // read back
   assign csr_prdata   = hit ? {{(CSR_DW-VC_W){1'b0}}, vc_ff} : '0;
   assign csr_pready   = 1'b1;
   assign vertex_count = vc_ff;

endmodule

`default_nettype wire

/* rtl/core/glcr_ctrl.sv */
`default_nettype none

module glcr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output glcr_pkg::dp_cmd_type   cmd,
   input  glcr_pkg::dp_sts_type   sts
);
   import glcr_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_PIVOT,
      S_CPL,
      S_CPL_TAIL,
      S_SWEEP,
      S_SWEEP_TAIL,
      S_FETCH,
      S_RESULT
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.load = req_tvalid;
            if (req_tvalid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            if (sts.mode == MODE_WR_COLOR) begin
               cmd.color_wr = 1'b1;
               state_in     = S_FETCH;
            end else if (!sts.ok) begin
               state_in = S_RESULT;
            end else begin
               case (sts.mode)
                  MODE_WR_ROW: begin
                     cmd.a_wr_row = 1'b1;
                     state_in     = S_SWEEP;
                  end
                  MODE_COMPLEMENT: begin
                     cmd.a_rd_pivot = 1'b1;
                     state_in       = S_PIVOT;
                  end
                  default: begin
                     state_in = S_FETCH;
                  end
               endcase
            end
         end
         S_PIVOT: begin
            cmd.nb_load = 1'b1;
            state_in    = S_CPL;
         end
         // one row read per cycle, its write-back follows in the next cycle
         S_CPL: begin
            cmd.cpl_rd  = 1'b1;
            cmd.cnt_inc = 1'b1;
            if (sts.cnt_last_act) state_in = S_CPL_TAIL;
         end
         S_CPL_TAIL: begin
            cmd.color_flip = 1'b1;
            state_in       = S_FETCH;
         end
         // column sweep keeps the transposed copy in step
         S_SWEEP: begin
            cmd.sweep_rd = 1'b1;
            cmd.cnt_inc  = 1'b1;
            if (sts.cnt_last_all) state_in = S_SWEEP_TAIL;
         end
         S_SWEEP_TAIL: begin
            state_in = S_FETCH;
         end
         S_FETCH: begin
            cmd.a_rd_pivot = 1'b1;
            state_in       = S_RESULT;
         end
         S_RESULT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/glcr_dpath.sv */
`default_nettype none

`include "graph_local_complement_recolor_macros.svh"

module glcr_dpath #(
   parameter int MAX_VERTICES = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  glcr_pkg::dp_cmd_type            cmd,
   output glcr_pkg::dp_sts_type            sts,
   input  logic [glcr_pkg::VC_W-1:0]       vertex_count,
   input  glcr_pkg::mode_type              req_mode,
   input  logic [glcr_pkg::VERTEX_W-1:0]   req_vertex,
   input  logic [glcr_pkg::BITS_W-1:0]     req_bits,
   input  logic                            rsp_tready,
   output logic                            rsp_valid,
   output logic [glcr_pkg::BITS_W-1:0]     rsp_row_bits,
   output logic [glcr_pkg::BITS_W-1:0]     rsp_color_bits,
   output logic                            rsp_error
);
   import glcr_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);

   typedef logic [MAX_VERTICES-1:0] row_type;

   // row memory and its transposed copy (column memory)
   row_type a_mem [MAX_VERTICES];
   row_type b_mem [MAX_VERTICES];
   row_type a_vld_ff, b_vld_ff;

   mode_type            mode_ff;
   logic [VERTEX_W-1:0] v_ff;
   logic [BITS_W-1:0]   bits_ff;
   logic [CW-1:0]       n_ff;
   logic                ok_ff;
   logic [AW-1:0]       cnt_ff, widx_ff;
   logic                cpl_pend_ff, sweep_pend_ff;
   row_type             nb_ff, color_ff;
   row_type             a_q_ff, b_q_ff;
   logic                a_qv_ff, b_qv_ff;
   logic                rsp_valid_ff, rsp_error_ff;
   logic [BITS_W-1:0]   rsp_row_ff, rsp_color_ff;

   logic [VC_W:0]          vc_ext, max_ext, n_full;
   logic                   ok_in;
   logic [AW+VERTEX_W-1:0] v_ext;
   logic [AW-1:0]          v_idx;
   logic [MAX_VERTICES+BITS_W-1:0] bits_ext, aq_ext, col_ext;
   row_type                bits_m, a_q, b_q, nmask, above, r_hot, v_hot, blk, flipped;
   row_type                a_new, b_new, b_sweep, a_wdata, b_wdata;
   logic                   cpl_we, a_we, b_we, a_rd, b_rd;
   logic [AW-1:0]          a_waddr, a_raddr;
   logic [AW:0]            cnt_p1;

   // active count and range check on the incoming transaction
   assign vc_ext  = {1'b0, vertex_count};
   assign max_ext = (VC_W+1)'(MAX_VERTICES);
   assign n_full  = (vc_ext > max_ext) ? max_ext : vc_ext;
   assign ok_in   = {{(VC_W+1-VERTEX_W){1'b0}}, req_vertex} < n_full;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         v_ff    <= req_vertex;
         bits_ff <= req_bits;
         n_ff    <= n_full[CW-1:0];
         ok_ff   <= ok_in;
      end
   end

   assign v_ext    = {{AW{1'b0}}, v_ff};
   assign v_idx    = v_ext[AW-1:0];
   assign bits_ext = {{MAX_VERTICES{1'b0}}, bits_ff};
   assign bits_m   = bits_ext[MAX_VERTICES-1:0];

   // row counter and write-back pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         cpl_pend_ff   <= 1'b0;
         sweep_pend_ff <= 1'b0;
      end else begin
         if (cmd.load || cmd.nb_load) begin
            cnt_ff <= '0;
         end else if (cmd.cnt_inc) begin
            cnt_ff <= cnt_ff + AW'(1);
         end
         cpl_pend_ff   <= cmd.cpl_rd;
         sweep_pend_ff <= cmd.sweep_rd;
      end
   end

   always_ff @(posedge clock) begin
      widx_ff <= cnt_ff;
   end

   assign cnt_p1 = {1'b0, cnt_ff} + {{AW{1'b0}}, 1'b1};

   // read ports, invalid rows read as zero
   assign a_rd    = cmd.a_rd_pivot | cmd.cpl_rd;
   assign a_raddr = cmd.cpl_rd ? cnt_ff : v_idx;
   assign b_rd    = cmd.cpl_rd | cmd.sweep_rd;

   always_ff @(posedge clock) begin
      if (a_rd) a_q_ff <= a_mem[a_raddr];
      if (b_rd) b_q_ff <= b_mem[cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_qv_ff <= 1'b0;
         b_qv_ff <= 1'b0;
      end else begin
         if (a_rd) a_qv_ff <= a_vld_ff[a_raddr];
         if (b_rd) b_qv_ff <= b_vld_ff[cnt_ff];
      end
   end

   assign a_q = a_qv_ff ? a_q_ff : '0;
   assign b_q = b_qv_ff ? b_q_ff : '0;

   // neighbour mask limited to the active count
   always_comb begin
      for (int c = 0; c < MAX_VERTICES; c++) begin
         nmask[c] = (CW'(c) < n_ff);
         above[c] = (AW'(c) > widx_ff);
      end
   end

   // new neighbour bits: upper part from the row, lower part from the column
   assign r_hot   = row_type'(1) << widx_ff;
   assign v_hot   = row_type'(1) << v_idx;
   assign blk     = nb_ff & ~r_hot;
   assign flipped = ~((a_q & above) | (b_q & ~above));
   assign a_new   = (a_q & ~blk) | (flipped & blk);
   assign b_new   = (b_q & ~blk) | (flipped & blk);
   assign cpl_we  = cpl_pend_ff & nb_ff[widx_ff];

   // row write puts its bit into every column
   assign b_sweep = (b_q & ~v_hot) | ({MAX_VERTICES{bits_m[widx_ff]}} & v_hot);

   // write ports
   assign a_we    = cmd.a_wr_row | cpl_we;
   assign a_waddr = cmd.a_wr_row ? v_idx : widx_ff;
   assign a_wdata = cmd.a_wr_row ? bits_m : a_new;
   assign b_we    = cpl_we | sweep_pend_ff;
   assign b_wdata = sweep_pend_ff ? b_sweep : b_new;

   always_ff @(posedge clock) begin
      if (a_we) a_mem[a_waddr] <= a_wdata;
      if (b_we) b_mem[widx_ff] <= b_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= '0;
         b_vld_ff <= '0;
      end else begin
         if (a_we) a_vld_ff[a_waddr] <= 1'b1;
         if (b_we) b_vld_ff[widx_ff] <= 1'b1;
      end
   end

   // neighbour set and coloring
   always_ff @(posedge clock) begin
      if (cmd.nb_load) nb_ff <= a_q & nmask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= '0;
      end else if (cmd.color_wr) begin
         color_ff <= bits_m;
      end else if (cmd.color_flip) begin
         color_ff <= color_ff ^ nb_ff;
      end
   end

   // response register
   assign aq_ext  = {{BITS_W{1'b0}}, a_q};
   assign col_ext = {{BITS_W{1'b0}}, color_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_row_ff   <= ok_ff ? aq_ext[BITS_W-1:0] : '0;
         rsp_color_ff <= col_ext[BITS_W-1:0];
         rsp_error_ff <= !ok_ff && (mode_ff != MODE_WR_COLOR);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row_bits   = rsp_row_ff;
   assign rsp_color_bits = rsp_color_ff;
   assign rsp_error      = rsp_error_ff;

   // status
   assign sts.mode         = mode_ff;
   assign sts.ok           = ok_ff;
   assign sts.cnt_last_all = (cnt_ff == AW'(MAX_VERTICES - 1));
   assign sts.cnt_last_act = (cnt_p1 == (AW+1)'(n_ff));
   assign sts.out_free     = !rsp_valid_ff || rsp_tready;

   `GLCR_ASSERT_IMP(a_row_port_single, clock, reset, cmd.a_wr_row, !cpl_pend_ff, "row memory written from two sources")
   `GLCR_ASSERT_IMP(a_rmw_distinct, clock, reset, (cpl_pend_ff || sweep_pend_ff) && (cmd.cpl_rd || cmd.sweep_rd), widx_ff != cnt_ff, "read meets pending write address")
   `GLCR_ASSERT_IMP(a_rsp_no_overrun, clock, reset, rsp_valid_ff && !rsp_tready, !cmd.out_load, "response overwritten while stalled")
   `GLCR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid_ff && !rsp_tready, rsp_valid_ff && $stable(rsp_row_ff), "response dropped while stalled")

endmodule

`default_nettype wire

/* rtl/core/graph_local_complement_recolor.sv */
// Local complementation engine on a two-colored graph.
// req channel: one transaction per command. tuser holds the mode (write row,
// write coloring, complement at pivot, read row); tdata holds vertex and bits.
// rsp channel: exactly one transaction per command with the addressed row
// after the command, the full coloring and an out-of-range error flag.
// csr port: register 0 is vertex_count (active vertices, reset 32).
// Read row and write coloring need no row sweep; write row sweeps all
// MAX_VERTICES rows of the column memory and complementation the active
// rows, with up to one row of the row memory and one of the column memory read and written per cycle.
// One command is in flight at a time; the next is taken once the current
// result is loaded in the output register, so a stalled receiver only holds
// the engine when a second result is ready.
// Reset clears the matrix and the coloring (per-row valid flags, no sweep),
// drops any pending response and restores vertex_count.
`default_nettype none

module graph_local_complement_recolor #(
   parameter int MAX_VERTICES = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [39:0]                 req_tdata,   // vertex[4:0], bits[36:5], zero pad
   input  logic [1:0]                  req_tuser,   // mode[1:0]
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [63:0]                 rsp_tdata,   // row_bits[31:0], color_bits[63:32]
   output logic [0:0]                  rsp_tuser,   // error[0]
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [glcr_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [glcr_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [glcr_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);
   import glcr_pkg::*;

   dp_cmd_type          cmd;
   dp_sts_type          sts;
   logic [VC_W-1:0]     vertex_count;
   logic [BITS_W-1:0]   row_bits, color_bits;
   logic                error;

   glcr_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .vertex_count (vertex_count)
   );

   glcr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   glcr_dpath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .vertex_count   (vertex_count),
      .req_mode       (mode_type'(req_tuser)),
      .req_vertex     (req_tdata[VERTEX_W-1:0]),
      .req_bits       (req_tdata[VERTEX_W+BITS_W-1:VERTEX_W]),
      .rsp_tready     (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .rsp_row_bits   (row_bits),
      .rsp_color_bits (color_bits),
      .rsp_error      (error)
   );

   // pack result transaction
   assign rsp_tdata = {color_bits, row_bits};
   assign rsp_tuser = error;

endmodule

`default_nettype wire

/* tb/glcr_recolor_checker.sv */
`default_nettype none

module glcr_recolor_checker
   import glcr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [39:0]         req_tdata,   // vertex[4:0], bits[36:5], zero pad
   input  logic [1:0]          req_tuser,   // mode[1:0]
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [63:0]         rsp_tdata,   // row_bits[31:0], color_bits[63:32]
   input  logic [0:0]          rsp_tuser,   // error[0]
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   input  logic                csr_pready,
   output int                  outstanding,
   output int                  mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NV = 32;
   localparam logic [CSR_AW-1:0] VC_ADDR = CSR_AW'(4 * int'(REG_VERTEX_COUNT));

   typedef struct packed {
      logic [31:0] row;
      logic [31:0] color;
      logic        err;
   } rsp_fields_type;

   // shadow copy of the graph, coloring and vertex count
   logic [31:0]     adj [NV];
   logic [31:0]     colors;
   logic [VC_W-1:0] vcount;
   rsp_fields_type  row_color_q [$];

   initial mismatch_count = 0;

   function automatic int active_n();
      return (vcount > VC_W'(NV)) ? NV : int'(vcount);
   endfunction

   // toggle every neighbour pair and flip neighbour colors
   function automatic void complement_at(input int pivot, input int n);
      logic [31:0] snap [NV];
      logic [31:0] nb;
      logic        flip;
      nb = adj[pivot] & ((n >= NV) ? '1 : ((32'd1 << n) - 32'd1));
      snap = adj;
      for (int i = 0; i < n; i++) begin
         for (int j = i + 1; j < n; j++) begin
            if (nb[i] && nb[j]) begin
               flip = ~snap[i][j];
               adj[i][j] = flip;
               adj[j][i] = flip;
            end
         end
      end
      colors ^= nb;
   endfunction

   // apply one command to the shadow state and return its response
   function automatic rsp_fields_type run_command(input mode_type m, input logic [4:0] v,
                                                  input logic [31:0] b);
      rsp_fields_type r;
      int             n;
      logic           in_range;
      n = active_n();
      in_range = int'(v) < n;
      r = '0;
      if (m == MODE_WR_COLOR) begin
         colors = b;
         if (in_range) r.row = adj[v];
      end else if (!in_range) begin
         r.err = 1'b1;
      end else begin
         if (m == MODE_WR_ROW) adj[v] = b;
         else if (m == MODE_COMPLEMENT) complement_at(int'(v), n);
         r.row = adj[v];
      end
      r.color = colors;
      return r;
   endfunction

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // watch all three ports at each rising edge
   always @(posedge clock) begin
      rsp_fields_type got;
      rsp_fields_type want;
      rsp_fields_type pred;
      if (reset) begin
         for (int i = 0; i < NV; i++) adj[i] = '0;
         colors = '0;
         vcount = VC_RESET;
         row_color_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == VC_ADDR)
            vcount = csr_pwdata[VC_W-1:0];
         // response transaction against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser[0]};
            if (row_color_q.size() == 0) begin
               report("response with nothing pending", got.row, '0);
            end else begin
               want = row_color_q.pop_front();
               if (got.row !== want.row) report("row_bits", got.row, want.row);
               if (got.color !== want.color) report("color_bits", got.color, want.color);
               if (got.err !== want.err) report("error", 32'(got.err), 32'(want.err));
            end
         end
         // command transaction
         if (req_tvalid && req_tready) begin
            pred = run_command(mode_type'(req_tuser), req_tdata[4:0], req_tdata[36:5]);
            row_color_q.insert(row_color_q.size(), pred);
         end
      end
      outstanding <= row_color_q.size();
   end

endmodule

`default_nettype wire

/* tb/graph_local_complement_recolor_tb.sv */
`default_nettype none

module graph_local_complement_recolor_tb;
   import glcr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_AW-1:0] VC_ADDR = CSR_AW'(4 * int'(REG_VERTEX_COUNT));
   localparam int SETTLE = 48;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [39:0]       req_tdata;   // vertex[4:0], bits[36:5], zero pad
   logic [1:0]        req_tuser;   // mode[1:0]
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [63:0]       rsp_tdata;   // row_bits[31:0], color_bits[63:32]
   logic [0:0]        rsp_tuser;   // error[0]
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   int outstanding;
   int mismatch_count;
   int burst_left;

   graph_local_complement_recolor #(
      .MAX_VERTICES(32)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   glcr_recolor_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .outstanding   (outstanding),
      .mismatch_count(mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard limit on the run
   initial begin
      #9_000_000;
      $display("FAIL graph_local_complement_recolor");
      $finish;
   end

   // offer one command, then sometimes end the burst with a gap
   task automatic issue(input mode_type m, input logic [4:0] v, input logic [31:0] b);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= m;
      req_tdata  <= {3'b000, b, v};
      do @(posedge clock); while (!req_tready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 24);
         gap = $urandom_range(1, 40);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending and wait for every response to come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_count(input logic [VC_W-1:0] vc);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= VC_ADDR;
      csr_pwdata  <= CSR_DW'(vc);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // random command, mostly addressing active vertices
   task automatic random_item(input int n);
      int          pick;
      mode_type    m;
      logic [4:0]  v;
      logic [31:0] b;
      pick = $urandom_range(0, 99);
      if (pick < 25) m = MODE_WR_ROW;
      else if (pick < 35) m = MODE_WR_COLOR;
      else if (pick < 70) m = MODE_COMPLEMENT;
      else m = MODE_RD_ROW;
      if (n > 0 && $urandom_range(0, 9) != 0) v = 5'($urandom_range(0, n - 1));
      else v = 5'($urandom_range(0, 31));
      case ($urandom_range(0, 9))
         0:       b = '1;
         1:       b = '0;
         2, 3:    b = $urandom() & ((n >= 32) ? 32'hffff_ffff : ((32'd1 << n) - 32'd1));
         default: b = $urandom();
      endcase
      issue(m, v, b);
   endtask

   // receiver: randomly chosen stall patterns plus two long hold-offs
   initial begin
      int style;
      int len;
      int cyc;
      int hold_at;
      int holds;
      cyc = 0;
      hold_at = 2000;
      holds = 0;
      rsp_tready <= 1'b0;
      wait (!reset);
      forever begin
         if (holds < 2 && cyc >= hold_at) begin
            for (int i = 0; i < 300; i++) begin
               @(posedge clock);
               rsp_tready <= 1'b0;
            end
            cyc += 300;
            hold_at = cyc + 40000;
            holds++;
         end
         style = $urandom_range(0, 3);
         len = (style == 3) ? $urandom_range(1, 12) : $urandom_range(5, 60);
         for (int i = 0; i < len; i++) begin
            @(posedge clock);
            case (style)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= ($urandom_range(0, 3) != 0);
               default: rsp_tready <= 1'b0;
            endcase
            cyc++;
         end
      end
   end

   // stimulus and verdict
   initial begin
      logic [VC_W-1:0] phase_vc [8];
      int              n;
      int              count;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= MODE_WR_ROW;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      burst_left  = 6;
      reset <= 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full count after reset: fresh read, full row with self bit, colorings
      issue(MODE_RD_ROW,     5'd0,  32'h0000_0000);
      issue(MODE_WR_ROW,     5'd31, 32'hffff_ffff);
      issue(MODE_WR_COLOR,   5'd31, 32'hffff_ffff);
      issue(MODE_WR_COLOR,   5'd0,  32'h0000_0000);
      issue(MODE_COMPLEMENT, 5'd31, 32'h0000_0000);
      issue(MODE_RD_ROW,     5'd31, 32'h1234_5678);
      issue(MODE_RD_ROW,     5'd0,  32'h0000_0000);
      issue(MODE_WR_ROW,     5'd0,  32'ha5a5_a5a5);
      issue(MODE_COMPLEMENT, 5'd0,  32'hffff_ffff);
      // pivot with no neighbours
      issue(MODE_WR_ROW,     5'd5,  32'h0000_0000);
      issue(MODE_COMPLEMENT, 5'd5,  32'h0000_0000);
      issue(MODE_WR_COLOR,   5'd17, 32'h5a5a_5a5a);

      // small count: out of range commands, bits above the count kept
      drain();
      set_count(6'd3);
      issue(MODE_WR_ROW,     5'd3,  32'h0000_0001);
      issue(MODE_RD_ROW,     5'd31, 32'h0000_0000);
      issue(MODE_COMPLEMENT, 5'd4,  32'h0000_0000);
      issue(MODE_WR_COLOR,   5'd10, 32'hc000_0003);
      issue(MODE_WR_ROW,     5'd2,  32'hf000_0007);
      issue(MODE_COMPLEMENT, 5'd2,  32'h0000_0000);
      issue(MODE_RD_ROW,     5'd1,  32'h0000_0000);

      // zero count: everything out of range except coloring writes
      drain();
      set_count(6'd0);
      issue(MODE_RD_ROW,     5'd0,  32'h0000_0000);
      issue(MODE_WR_COLOR,   5'd0,  32'h0000_ffff);
      issue(MODE_COMPLEMENT, 5'd0,  32'h0000_0000);

      // count above the maximum saturates
      drain();
      set_count(6'd63);
      issue(MODE_COMPLEMENT, 5'd31, 32'h0000_0000);

      // single vertex: self loop is the only neighbour
      drain();
      set_count(6'd1);
      issue(MODE_WR_ROW,     5'd0,  32'h0000_0001);
      issue(MODE_COMPLEMENT, 5'd0,  32'h0000_0000);

      // random phases over several vertex counts
      phase_vc = '{6'd32, 6'd7, 6'd63, 6'd1, 6'd0, 6'd2, 6'd32, 6'd33};
      phase_vc[5] = VC_W'($urandom_range(2, 31));
      phase_vc[7] = VC_W'($urandom_range(33, 62));
      for (int p = 0; p < 8; p++) begin
         drain();
         set_count(phase_vc[p]);
         n = (phase_vc[p] > 6'd32) ? 32 : int'(phase_vc[p]);
         count = (n == 0) ? 40 : 260;
         for (int k = 0; k < count; k++) begin
            if (p % 2 == 1 && k == count / 2) drain();
            random_item(n);
         end
      end

      drain();
      if (mismatch_count == 0) begin
         $display("PASS graph_local_complement_recolor");
      end else begin
         $display("FAIL graph_local_complement_recolor");
      end
      $finish;
   end

endmodule

`default_nettype wire
